// ===== rtl/core/rlwe_pkg.sv =====
// shared types and constants for the run-length word encoder
package rlwe_pkg;

  localparam int IdWidth    = 32;
  localparam int CountWidth = 32;
  localparam int ByteWidth  = 8;
  localparam int RunBytes   = 8;
  localparam int SlotWidth  = $clog2(2 * RunBytes);

  localparam logic [CountWidth-1:0] MaxCount = '1;

  typedef struct packed {
    logic [IdWidth-1:0] id_value;
    logic               frame_last;
  } in_word_t;

  typedef struct packed {
    logic [ByteWidth-1:0] out_byte;
    logic                 item_last;
    logic                 frame_end;
  } out_word_t;

  typedef struct packed {
    logic [CountWidth-1:0] count;
    logic [IdWidth-1:0]    value;
  } run_t;

  // one or two finished runs that a single input word produces
  typedef struct packed {
    run_t first_run;
    run_t second_run;
    logic two_runs;
    logic frame_end;
  } run_job_t;

endpackage

// ===== rtl/core/rlwe_run_tracker.sv =====
// input register and open-run tracking, hands finished runs to the serializer
module rlwe_run_tracker (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  rlwe_pkg::in_word_t in_data,
  output logic               job_valid,
  input  logic               job_ready,
  output rlwe_pkg::run_job_t job
);

  logic                                hold_valid;
  rlwe_pkg::in_word_t                  hold;
  logic [rlwe_pkg::IdWidth-1:0]        cur_value;
  logic [rlwe_pkg::CountWidth-1:0]     cur_count;
  logic                                run_open;

  logic                                close_old;
  logic                                emits;
  logic                                consume;
  logic [rlwe_pkg::IdWidth-1:0]        new_value;
  logic [rlwe_pkg::CountWidth-1:0]     new_count;

  always_comb begin
    close_old = 1'b0;
    new_value = hold.id_value;
    new_count = rlwe_pkg::CountWidth'(1);
    if (run_open) begin
      if (hold.id_value == cur_value && cur_count != rlwe_pkg::MaxCount) begin
        new_value = cur_value;
        new_count = cur_count + rlwe_pkg::CountWidth'(1);
      end else begin
        close_old = 1'b1;
      end
    end
  end

  assign emits     = close_old || hold.frame_last;
  assign job_valid = hold_valid && emits;
  // words that close no run pass without waiting on the serializer
  assign consume   = hold_valid && (!emits || job_ready);
  assign in_ready  = !hold_valid || consume;

  always_comb begin
    job.first_run.count  = close_old ? cur_count : new_count;
    job.first_run.value  = close_old ? cur_value : new_value;
    job.second_run.count = new_count;
    job.second_run.value = new_value;
    job.two_runs         = close_old && hold.frame_last;
    job.frame_end        = hold.frame_last;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      hold_valid <= 1'b0;
    end else if (in_ready) begin
      hold_valid <= in_valid;
    end
    if (in_ready && in_valid) begin
      hold <= in_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cur_value <= '0;
      cur_count <= '0;
      run_open  <= 1'b0;
    end else if (consume) begin
      if (hold.frame_last) begin
        cur_value <= '0;
        cur_count <= '0;
        run_open  <= 1'b0;
      end else begin
        cur_value <= new_value;
        cur_count <= new_count;
        run_open  <= 1'b1;
      end
    end
  end

endmodule

// ===== rtl/core/rlwe_byte_serializer.sv =====
// result register and byte counter, sends one byte of a run per cycle while out_ready is high
module rlwe_byte_serializer (
  input  logic                clk,
  input  logic                rst,
  input  logic                job_valid,
  output logic                job_ready,
  input  rlwe_pkg::run_job_t  job,
  output logic                out_valid,
  input  logic                out_ready,
  output rlwe_pkg::out_word_t out_data
);

  logic                           busy;
  rlwe_pkg::run_job_t             cur;
  logic [rlwe_pkg::SlotWidth-1:0] slot;
  logic                           at_end;
  rlwe_pkg::run_t                 sel_run;
  logic [rlwe_pkg::IdWidth-1:0]   sel_word;

  assign at_end    = slot == {cur.two_runs, {(rlwe_pkg::SlotWidth-1){1'b1}}};
  assign out_valid = busy;
  assign job_ready = !busy || (out_ready && at_end);

  always_comb begin
    sel_run  = slot[rlwe_pkg::SlotWidth-1] ? cur.second_run : cur.first_run;
    // count first, then value, each least significant byte first
    sel_word = slot[2] ? sel_run.value : sel_run.count;
    out_data.out_byte  = sel_word[{slot[1:0], 3'b000} +: rlwe_pkg::ByteWidth];
    out_data.item_last = at_end;
    out_data.frame_end = at_end && cur.frame_end;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      slot <= '0;
    end else if (job_ready) begin
      busy <= job_valid;
      slot <= '0;
    end else if (out_ready) begin
      slot <= slot + rlwe_pkg::SlotWidth'(1);
    end
    if (job_ready && job_valid) begin
      cur <= job;
    end
  end

endmodule

// ===== rtl/core/run_length_word_encoder.sv =====
// run-length word encoder top level
// Encodes a stream of 32-bit ids into (count, value) pairs, eight bytes per
// run: the 32-bit count, then the 32-bit value, each least significant byte
// first, one byte per output word. A word that extends the open run is taken
// every cycle while no run closes. A word that closes a run (new id, count at
// its 32-bit maximum, or frame_last) yields 8 bytes, or 16 when it both closes
// a run and ends the frame; the byte serializer sends one byte per cycle while
// out_ready is high. The serializer takes its next job in the cycle its last
// byte leaves, and an input register in front lets the next word be accepted
// while bytes are still going out. item_last marks the last byte a word
// causes, frame_end the last byte of the frame.
module run_length_word_encoder (
  input  logic                clk,
  input  logic                rst,
  // input words
  input  logic                in_valid,
  output logic                in_ready,
  input  rlwe_pkg::in_word_t  in_data,
  // encoded bytes
  output logic                out_valid,
  input  logic                out_ready,
  output rlwe_pkg::out_word_t out_data
);

  // finished runs travel from the tracker to the serializer
  logic               job_valid;
  logic               job_ready;
  rlwe_pkg::run_job_t job;

  // open-run state, compare and increment
  rlwe_run_tracker u_tracker (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .job_valid (job_valid),
    .job_ready (job_ready),
    .job       (job)
  );

  // byte-at-a-time output of one or two runs
  rlwe_byte_serializer u_serializer (
    .clk       (clk),
    .rst       (rst),
    .job_valid (job_valid),
    .job_ready (job_ready),
    .job       (job),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule

// ===== rtl/core/rlwe_checker.sv =====
// port-level checks for the run-length word encoder
module rlwe_checker (
  input logic                clk,
  input logic                rst,
  input logic                in_valid,
  input logic                in_ready,
  input rlwe_pkg::in_word_t  in_data,
  input logic                out_valid,
  input logic                out_ready,
  input rlwe_pkg::out_word_t out_data
);

  // a stalled byte stays put
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("output byte changed while stalled");

  // frame end only on the last byte of a word
  a_frame_end_last: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_data.frame_end |-> out_data.item_last)
    else $error("frame_end without item_last");

  // nothing pending right after reset
  a_reset_empty: assert property (@(posedge clk)
    $past(rst) |-> !out_valid && in_ready)
    else $error("block not empty after reset");

  // a frame-ending word accepted while the output is idle produces at least its closing run
  a_frame_end_out: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready && in_data.frame_last && !out_valid |=> ##1 out_valid)
    else $error("frame end produced no bytes");

endmodule

bind run_length_word_encoder rlwe_checker u_rlwe_checker (
  .clk       (clk),
  .rst       (rst),
  .in_valid  (in_valid),
  .in_ready  (in_ready),
  .in_data   (in_data),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_data  (out_data)
);
